FILE: design/fgnh_pkg.sv
// Package for the fractal gradient-noise height pipeline.
// Holds widths, register indexes, reset values, hash constants, the word type
// and the quarter-wave sine generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fgnh_pkg;

    localparam int PIX_W      = 12;
    localparam int INV_W      = 24;
    localparam int BC_W       = 16;
    localparam int RC_W       = 20;
    localparam int SEED_W     = 64;
    localparam int H_W        = 10;
    localparam int PROD_W     = PIX_W + INV_W;
    localparam int ACC_W      = 34;
    localparam int NOISE_W    = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam int DEF_OCTAVES         = 10;
    localparam int DEF_SINE_TABLE_BITS = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_NOISE_SEED     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_SCALE      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_CONTRAST  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RIVER_CONTRAST = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RIVER_MODE     = 3'd4;

    localparam logic [SEED_W-1:0] RST_NOISE_SEED     = '0;
    localparam logic [INV_W-1:0]  RST_INV_SCALE      = 24'd69905;
    localparam logic [BC_W-1:0]   RST_BASE_CONTRAST  = 16'd9421;
    localparam logic [RC_W-1:0]   RST_RIVER_CONTRAST = 20'd44237;

    localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
    localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
    localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

    localparam logic [30:0] CLAMP_Q30 = 31'd1288490189;

    typedef struct packed {
        logic                     vld;
        logic [PROD_W-1:0]        prod_x;
        logic [PROD_W-1:0]        prod_y;
        logic signed [ACC_W-1:0]  acc;
    } t_word;

    function automatic logic [14:0] quarter_sine(input int stb, input int k);
        longint t;
        longint x;
        longint x2;
        longint u;
        longint one;
        one = 64'sd1 << 30;
        t   = longint'(k) << (30 - stb);
        x   = (t * 64'sd1686629713) >>> 30;
        x2  = (x * x) >>> 30;
        u   = one - x2 / 72;
        u   = one - ((x2 * u) >>> 30) / 42;
        u   = one - ((x2 * u) >>> 30) / 20;
        u   = one - ((x2 * u) >>> 30) / 6;
        return 15'((((x * u) >>> 30) + 32768) >>> 16);
    endfunction

endpackage
`default_nettype wire

FILE: design/fgnh_cell.sv
// One octave cell: hashes the four lattice corners, looks up gradients,
// blends with smoothstep weights and adds the octave into the running sum.
// Depends on fgnh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fgnh_cell #(
    parameter int OCT             = 0,
    parameter int SINE_TABLE_BITS = fgnh_pkg::DEF_SINE_TABLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [fgnh_pkg::SEED_W-1:0]     i_seed,
    input  fgnh_pkg::t_word                 i_word,
    output fgnh_pkg::t_word                 o_word
);
    import fgnh_pkg::*;

    localparam int Q     = 1 << SINE_TABLE_BITS;
    localparam int PH_W  = SINE_TABLE_BITS + 2;
    localparam int IX_W  = SINE_TABLE_BITS + 1;
    localparam int LAT   = 10;
    localparam int SHIFT = 16 - OCT;

    logic [14:0] lut [0:Q];
    for (genvar k = 0; k <= Q; k++) begin : g_lut
        assign lut[k] = quarter_sine(SINE_TABLE_BITS, k);
    end

    // delay line for the word fields
    logic [LAT-2:0]          r_vld;
    logic [PROD_W-1:0]       r_px  [0:LAT-2];
    logic [PROD_W-1:0]       r_py  [0:LAT-2];
    logic signed [ACC_W-1:0] r_acc [0:LAT-2];
    logic                    r_out_vld;
    logic [PROD_W-1:0]       r_out_px;
    logic [PROD_W-1:0]       r_out_py;
    logic signed [ACC_W-1:0] r_out_acc;

    logic [31:0] cx, cy;
    logic [15:0] x0, x1, y0, y1;

    logic [31:0] r1_ax [0:1];
    logic [31:0] r1_by [0:1];
    logic [15:0] r1_fx, r1_fy;

    logic [31:0] r2_ma [0:1];
    logic [31:0] r2_by [0:1];
    logic [15:0] r2_fx, r2_fy, r2_w2x, r2_w2y;

    logic [31:0] r3_ma [0:1];
    logic [31:0] r3_mb [0:3];
    logic [15:0] r3_fx, r3_fy;
    logic [16:0] r3_sx, r3_sy;

    logic [31:0] r4_h [0:3];
    logic [15:0] r4_fx, r4_fy;
    logic [16:0] r4_sx, r4_sy;

    logic signed [15:0] r5_gx [0:3];
    logic signed [15:0] r5_gy [0:3];
    logic signed [15:0] n_gx  [0:3];
    logic signed [15:0] n_gy  [0:3];
    logic [15:0]        r5_fx, r5_fy;
    logic [16:0]        r5_sx, r5_sy;

    logic signed [NOISE_W-1:0] r6_n [0:3];
    logic signed [NOISE_W-1:0] n_n  [0:3];
    logic [16:0]               r6_sx, r6_sy;

    logic signed [38:0]        r7_d  [0:1];
    logic signed [NOISE_W-1:0] r7_n0 [0:1];
    logic [16:0]               r7_sy;

    logic signed [NOISE_W-1:0] r8_b [0:1];
    logic [16:0]               r8_sy;

    logic signed [38:0]        r9_d;
    logic signed [NOISE_W-1:0] r9_b0;

    logic signed [NOISE_W-1:0] noise;

    assign cx = 32'((64'(i_word.prod_x) << OCT) >> 4);
    assign cy = 32'((64'(i_word.prod_y) << OCT) >> 4);
    assign x0 = cx[31:16];
    assign y0 = cy[31:16];
    assign x1 = x0 + 16'd1;
    assign y1 = y0 + 16'd1;

    for (genvar c = 0; c < 4; c++) begin : g_corner
        logic [PH_W-1:0] p, pg;
        logic [IX_W-1:0] ix, iy;
        logic signed [16:0] dx, dy;
        logic signed [33:0] sum;

        assign p  = r4_h[c][31 -: PH_W];
        assign pg = p + PH_W'(Q);
        assign ix = p[SINE_TABLE_BITS]  ? (IX_W'(Q) - {1'b0, p[SINE_TABLE_BITS-1:0]})
                                        : {1'b0, p[SINE_TABLE_BITS-1:0]};
        assign iy = pg[SINE_TABLE_BITS] ? (IX_W'(Q) - {1'b0, pg[SINE_TABLE_BITS-1:0]})
                                        : {1'b0, pg[SINE_TABLE_BITS-1:0]};
        assign n_gx[c] = p[PH_W-1]  ? -$signed({1'b0, lut[ix]}) : $signed({1'b0, lut[ix]});
        assign n_gy[c] = pg[PH_W-1] ? -$signed({1'b0, lut[iy]}) : $signed({1'b0, lut[iy]});

        assign dx  = (c % 2 == 1) ? $signed({1'b0, r5_fx} - 17'h10000) : $signed({1'b0, r5_fx});
        assign dy  = (c / 2 == 1) ? $signed({1'b0, r5_fy} - 17'h10000) : $signed({1'b0, r5_fy});
        assign sum = 34'(dx * r5_gx[c]) + 34'(dy * r5_gy[c]);
        assign n_n[c] = NOISE_W'(sum >>> 16);
    end

    assign noise = r9_b0 + NOISE_W'(r9_d >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= {r_vld[LAT-3:0], i_word.vld};
            r_out_vld <= r_vld[LAT-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px[0]  <= i_word.prod_x;
            r_py[0]  <= i_word.prod_y;
            r_acc[0] <= i_word.acc;
            for (int s = 1; s < LAT - 1; s++) begin
                r_px[s]  <= r_px[s-1];
                r_py[s]  <= r_py[s-1];
                r_acc[s] <= r_acc[s-1];
            end

            r1_ax[0] <= {16'd0, x0} + i_seed[31:0];
            r1_ax[1] <= {16'd0, x1} + i_seed[31:0];
            r1_by[0] <= {16'd0, y0} + i_seed[63:32];
            r1_by[1] <= {16'd0, y1} + i_seed[63:32];
            r1_fx    <= cx[15:0];
            r1_fy    <= cy[15:0];

            for (int j = 0; j < 2; j++) begin
                r2_ma[j] <= r1_ax[j] * HASH_MUL_A;
                r2_by[j] <= r1_by[j];
            end
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_w2x <= 16'((32'(r1_fx) * 32'(r1_fx)) >> 16);
            r2_w2y <= 16'((32'(r1_fy) * 32'(r1_fy)) >> 16);

            for (int c = 0; c < 4; c++) begin
                r3_mb[c] <= (r2_by[c/2] ^ {r2_ma[c%2][15:0], r2_ma[c%2][31:16]}) * HASH_MUL_B;
            end
            r3_ma <= r2_ma;
            r3_fx <= r2_fx;
            r3_fy <= r2_fy;
            r3_sx <= 17'((34'(r2_w2x) * (34'd196608 - 34'({r2_fx, 1'b0}))) >> 16);
            r3_sy <= 17'((34'(r2_w2y) * (34'd196608 - 34'({r2_fy, 1'b0}))) >> 16);

            for (int c = 0; c < 4; c++) begin
                r4_h[c] <= (r3_ma[c%2] ^ {r3_mb[c][15:0], r3_mb[c][31:16]}) * HASH_MUL_C;
            end
            r4_fx <= r3_fx;
            r4_fy <= r3_fy;
            r4_sx <= r3_sx;
            r4_sy <= r3_sy;

            r5_gx <= n_gx;
            r5_gy <= n_gy;
            r5_fx <= r4_fx;
            r5_fy <= r4_fy;
            r5_sx <= r4_sx;
            r5_sy <= r4_sy;

            r6_n  <= n_n;
            r6_sx <= r5_sx;
            r6_sy <= r5_sy;

            for (int j = 0; j < 2; j++) begin
                r7_d[j]  <= 39'(21'(r6_n[2*j+1]) - 21'(r6_n[2*j])) *
                            39'($signed({1'b0, r6_sx}));
                r7_n0[j] <= r6_n[2*j];
            end
            r7_sy <= r6_sy;

            for (int j = 0; j < 2; j++) begin
                r8_b[j] <= r7_n0[j] + NOISE_W'(r7_d[j] >>> 16);
            end
            r8_sy <= r7_sy;

            r9_d  <= 39'(21'(r8_b[1]) - 21'(r8_b[0])) * 39'($signed({1'b0, r8_sy}));
            r9_b0 <= r8_b[0];

            r_out_px  <= r_px[LAT-2];
            r_out_py  <= r_py[LAT-2];
            r_out_acc <= r_acc[LAT-2] + (ACC_W'(noise) <<< SHIFT);
        end
    end

    assign o_word.vld    = r_out_vld;
    assign o_word.prod_x = r_out_px;
    assign o_word.prod_y = r_out_py;
    assign o_word.acc    = r_out_acc;

endmodule
`default_nettype wire

FILE: design/fgnh_map.sv
// Height mapping: contrast gain, clamp to +-1.2, then ground or river mapping.
// Four stages; the last one is the output register. Depends on fgnh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fgnh_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  fgnh_pkg::t_word                 i_word,
    input  logic [fgnh_pkg::BC_W-1:0]       i_base_contrast,
    input  logic [fgnh_pkg::RC_W-1:0]       i_river_contrast,
    input  logic                            i_river_mode,
    output logic                            o_valid,
    output logic signed [fgnh_pkg::H_W-1:0] o_height
);
    import fgnh_pkg::*;

    logic [3:0]         r_vld;
    logic signed [49:0] r1_v;
    logic               r2_neg, r3_neg;
    logic [30:0]        r2_m30;
    logic [39:0]        r3_g;
    logic [50:0]        r3_rr;
    logic signed [H_W-1:0] r4_h;

    logic [49:0]        mag;
    logic               clamp;
    logic [8:0]         gm;
    logic signed [10:0] hg;
    logic [58:0]        rt;
    logic [17:0]        rv;
    logic signed [18:0] hr;
    logic signed [H_W-1:0] n_h;

    assign mag   = r1_v[49] ? 50'(-r1_v) : 50'(r1_v);
    assign clamp = (53'({mag, 2'b00}) + 53'(mag)) > (53'd6 << 42);

    assign gm = 9'(r3_g >> 30);
    assign hg = r3_neg ? -$signed({2'b00, gm}) : $signed({2'b00, gm});
    assign rt = {r3_rr, 8'd0} - 59'(r3_rr);
    assign rv = 18'(rt >> 42);
    assign hr = $signed({1'b0, rv}) - 19'sd500;

    always_comb begin
        if (i_river_mode) begin
            if (hr > 19'sd0) begin
                n_h = '0;
            end else if (hr < -19'sd300) begin
                n_h = -10'sd400;
            end else begin
                n_h = H_W'(hr);
            end
        end else begin
            if (hg < -11'sd100) begin
                n_h = -10'sd100;
            end else if (hg < 11'sd50) begin
                n_h = 10'sd50;
            end else begin
                n_h = H_W'(hg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_word.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v   <= 50'(i_word.acc) * 50'($signed({1'b0, i_base_contrast}));
            r2_neg <= r1_v[49];
            r2_m30 <= clamp ? CLAMP_Q30 : 31'(mag >> 12);
            r3_neg <= r2_neg;
            r3_g   <= 40'(r2_m30) * 40'd280;
            r3_rr  <= 51'(r2_m30) * 51'(i_river_contrast);
            r4_h   <= n_h;
        end
    end

    assign o_valid  = r_vld[3];
    assign o_height = r4_h;

endmodule
`default_nettype wire

FILE: design/fractal_gradient_noise_height.sv
// Top level of the fractal gradient-noise terrain height pipeline.
// Instantiates one fgnh_cell per octave and fgnh_map; depends on fgnh_pkg.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  pixel    | i_valid, o_ready, i_pixel_x, i_pixel_y    | in
//  height   | o_valid, i_ready, o_terrain_height        | out
//  config   | i_cfg_we, i_cfg_addr, i_cfg_data          | in
//
// One word enters per cycle while the output is not held; a word passes the
// coordinate multiply register, which loads at the accepting edge, then the
// ten-stage octave cells chained one per octave and the four mapping stages.
// Reset is synchronous and clears only valid bits and configuration registers.
// When the output word is held, the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none
module fractal_gradient_noise_height #(
    parameter int OCTAVES         = fgnh_pkg::DEF_OCTAVES,
    parameter int SINE_TABLE_BITS = fgnh_pkg::DEF_SINE_TABLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [fgnh_pkg::PIX_W-1:0]           i_pixel_x,
    input  logic [fgnh_pkg::PIX_W-1:0]           i_pixel_y,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [fgnh_pkg::H_W-1:0]      o_terrain_height,
    input  logic                                 i_cfg_we,
    input  logic [fgnh_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [fgnh_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import fgnh_pkg::*;

    logic [SEED_W-1:0] r_seed;
    logic [INV_W-1:0]  r_inv_scale;
    logic [BC_W-1:0]   r_base_contrast;
    logic [RC_W-1:0]   r_river_contrast;
    logic              r_river_mode;

    logic              en;
    logic              r0_vld;
    logic [PROD_W-1:0] r0_px, r0_py;
    t_word             w [0:OCTAVES];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed           <= RST_NOISE_SEED;
            r_inv_scale      <= RST_INV_SCALE;
            r_base_contrast  <= RST_BASE_CONTRAST;
            r_river_contrast <= RST_RIVER_CONTRAST;
            r_river_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_NOISE_SEED:     r_seed           <= i_cfg_data;
                REG_INV_SCALE:      r_inv_scale      <= i_cfg_data[INV_W-1:0];
                REG_BASE_CONTRAST:  r_base_contrast  <= i_cfg_data[BC_W-1:0];
                REG_RIVER_CONTRAST: r_river_contrast <= i_cfg_data[RC_W-1:0];
                REG_RIVER_MODE:     r_river_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_px <= PROD_W'(i_pixel_x) * PROD_W'(r_inv_scale);
            r0_py <= PROD_W'(i_pixel_y) * PROD_W'(r_inv_scale);
        end
    end

    assign w[0].vld    = r0_vld;
    assign w[0].prod_x = r0_px;
    assign w[0].prod_y = r0_py;
    assign w[0].acc    = '0;

    for (genvar i = 0; i < OCTAVES; i++) begin : g_oct
        fgnh_cell #(
            .OCT             (i),
            .SINE_TABLE_BITS (SINE_TABLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_seed  (r_seed),
            .i_word  (w[i]),
            .o_word  (w[i+1])
        );
    end

    fgnh_map u_map (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_word           (w[OCTAVES]),
        .i_base_contrast  (r_base_contrast),
        .i_river_contrast (r_river_contrast),
        .i_river_mode     (r_river_mode),
        .o_valid          (o_valid),
        .o_height         (o_terrain_height)
    );

endmodule
`default_nettype wire
